FILE: hw/rtl/nph_pkg.sv
// Shared types, constants and helpers of the netpbm header parser.
`default_nettype none

package nph_pkg;

   // Bits of a width or height value.
   localparam int DIM_BITS   = 16;
   // Accumulator also has to hold a maximum value saturated at 65535.
   localparam int MAXV_BITS  = 16;
   localparam int ACC_BITS   = (DIM_BITS > MAXV_BITS) ? DIM_BITS : MAXV_BITS;
   localparam int SUM_BITS   = ACC_BITS + 4;
   localparam int PROD_BITS  = 2 * DIM_BITS;
   // Big enough for width*height*3, saturating above that.
   localparam int CNT_BITS   = 2 * DIM_BITS + 2;
   localparam int OUT_DIM_BITS  = 16;
   localparam int OUT_MAXV_BITS = 8;

   localparam int Q_DEPTH    = 4;
   localparam int Q_PTR_BITS = $clog2(Q_DEPTH);

   typedef logic [DIM_BITS-1:0]      dim_type;
   typedef logic [ACC_BITS-1:0]      acc_type;
   typedef logic [SUM_BITS-1:0]      sum_type;
   typedef logic [PROD_BITS-1:0]     prod_type;
   typedef logic [CNT_BITS-1:0]      cnt_type;
   typedef logic [MAXV_BITS-1:0]     maxv_type;
   typedef logic [OUT_DIM_BITS-1:0]  out_dim_type;
   typedef logic [OUT_MAXV_BITS-1:0] out_maxv_type;

   localparam dim_type  DIM_LIMIT  = '1;
   localparam maxv_type MAXVAL_SAT = '1;
   localparam out_maxv_type MAXVAL_LIMIT = '1;
   localparam cnt_type  CNT_SAT    = '1;

   localparam logic [7:0] CH_P     = 8'h50;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic [3:0] DIGIT_GRAY  = 4'd5;
   localparam logic [3:0] DIGIT_COLOR = 4'd6;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_MAGIC    = 3'd1,
      ST_TYPE     = 3'd2,
      ST_NUMBER   = 3'd3,
      ST_OVERFLOW = 3'd4,
      ST_SIZE     = 3'd5,
      ST_MAXVAL   = 3'd6
   } status_type;

   typedef enum logic [3:0] {
      PH_MAGIC_P,
      PH_MAGIC_T,
      PH_W_SKIP,
      PH_W_DIG,
      PH_H_SKIP,
      PH_H_DIG,
      PH_M_SKIP,
      PH_M_DIG,
      PH_PAYLOAD,
      PH_ERROR
   } phase_type;

   typedef enum logic [2:0] {
      CL_OTHER,
      CL_SPACE,
      CL_NEWLINE,
      CL_HASH,
      CL_DIGIT,
      CL_LETTER_P
   } byte_class_type;

   // One classified byte in the queue.
   typedef struct packed {
      byte_class_type cls;
      logic [3:0]     digit;
      logic           eof;
   } item_type;

   // End-of-file record handed from the parser to the size check.
   typedef struct packed {
      status_type status;
      logic       check;
      logic       is_color;
      dim_type    width;
      dim_type    height;
      maxv_type   maxval;
      cnt_type    count;
   } fin_type;

   function automatic out_dim_type sat_dim(input dim_type v);
      logic [DIM_BITS+OUT_DIM_BITS-1:0] wide;
      wide = {{OUT_DIM_BITS{1'b0}}, v};
      if (wide > {{DIM_BITS{1'b0}}, {OUT_DIM_BITS{1'b1}}}) begin
         return '1;
      end
      return wide[OUT_DIM_BITS-1:0];
   endfunction

   function automatic out_maxv_type sat_maxv(input maxv_type v);
      if (v > MAXV_BITS'(MAXVAL_LIMIT)) begin
         return '1;
      end
      return v[OUT_MAXV_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/nph_req_if.sv
// Request channel: one file byte per transfer.
`default_nettype none

interface nph_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_file;

   modport source (output valid, output data_byte, output end_of_file, input ready);
   modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/nph_rsp_if.sv
// Response channel: one parse result per file.
`default_nettype none

interface nph_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic        is_color;
   logic [15:0] image_width;
   logic [15:0] image_height;
   logic [7:0]  max_value;

   modport source (output valid, output status, output is_color, output image_width,
                   output image_height, output max_value, input ready);
   modport sink   (input valid, input status, input is_color, input image_width,
                   input image_height, input max_value, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/nph_front.sv
// Front end: takes request bytes and classifies them into the queue.
`default_nettype none

module nph_front import nph_pkg::*; (
   nph_req_if.sink   req_chan,
   input  wire logic q_full,
   output logic      q_push,
   output item_type  q_item
);

   logic [7:0] b;

   assign b              = req_chan.data_byte;
   assign req_chan.ready = !q_full;
   assign q_push         = req_chan.valid && !q_full;

   always_comb begin
      q_item.eof   = req_chan.end_of_file;
      q_item.digit = 4'(b - CH_ZERO);
      if (b inside {CH_SPACE, CH_TAB, CH_CR}) begin
         q_item.cls = CL_SPACE;
      end else if (b == CH_LF) begin
         q_item.cls = CL_NEWLINE;
      end else if (b == CH_HASH) begin
         q_item.cls = CL_HASH;
      end else if (b inside {[CH_ZERO:CH_NINE]}) begin
         q_item.cls = CL_DIGIT;
      end else if (b == CH_P) begin
         q_item.cls = CL_LETTER_P;
      end else begin
         q_item.cls = CL_OTHER;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/nph_fifo.sv
// Short queue of classified bytes between front end and parser.
`default_nettype none

module nph_fifo import nph_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type push_item,
   output logic          full,
   input  wire logic     pop,
   output item_type      pop_item,
   output logic          not_empty
);

   item_type                mem_ff [Q_DEPTH];
   logic [Q_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_PTR_BITS:0]     fill_ff, fill_in;

   assign full      = (fill_ff == (Q_PTR_BITS+1)'(Q_DEPTH));
   assign not_empty = (fill_ff != '0);
   assign pop_item  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/nph_back.sv
// Header parser state machine and payload counter; emits a record per file.
`default_nettype none

module nph_back import nph_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     q_valid,
   input  wire item_type q_item,
   output logic          q_pop,
   output logic          fin_valid,
   output fin_type       fin,
   input  wire logic     fin_ready
);

   phase_type  phase_ff, phase_in, phase_cons;
   logic       comment_ff, comment_in, comment_cons;
   acc_type    acc_ff, acc_in, acc_cons;
   dim_type    width_ff, width_in, width_cons;
   dim_type    height_ff, height_in, height_cons;
   maxv_type   maxval_ff, maxval_in, maxval_cons;
   logic       color_ff, color_in, color_cons;
   cnt_type    count_ff, count_in, count_cons;
   status_type err_ff, err_in, err_cons;
   logic       fin_valid_ff, fin_valid_in;
   fin_type    fin_ff, fin_in;

   sum_type    sum;
   logic       dim_over;
   logic       is_digit, is_space, is_hash;
   logic       active;
   logic       fin_free;
   logic       done;

   assign is_digit = (q_item.cls == CL_DIGIT);
   assign is_hash  = (q_item.cls == CL_HASH);
   assign is_space = (q_item.cls == CL_SPACE) || (q_item.cls == CL_NEWLINE);
   assign active   = (phase_ff != PH_ERROR) && !comment_ff;

   // acc*10 + digit
   assign sum      = (SUM_BITS'(acc_ff) << 3) + (SUM_BITS'(acc_ff) << 1)
                   + SUM_BITS'(q_item.digit);
   assign dim_over = (sum > SUM_BITS'(DIM_LIMIT));

   assign fin_free  = !fin_valid_ff || fin_ready;
   assign q_pop     = q_valid && (!q_item.eof || fin_free);
   assign done      = q_pop && q_item.eof;
   assign fin_valid = fin_valid_ff;
   assign fin       = fin_ff;

   // next phase
   always_comb begin
      phase_cons = phase_ff;
      if (active) begin
         case (phase_ff)
            PH_MAGIC_P: begin
               phase_cons = (q_item.cls == CL_LETTER_P) ? PH_MAGIC_T : PH_ERROR;
            end
            PH_MAGIC_T: begin
               if (is_digit && (q_item.digit == DIGIT_GRAY || q_item.digit == DIGIT_COLOR)) begin
                  phase_cons = PH_W_SKIP;
               end else begin
                  phase_cons = PH_ERROR;
               end
            end
            PH_W_SKIP, PH_H_SKIP, PH_M_SKIP: begin
               if (is_digit) begin
                  phase_cons = phase_type'(phase_ff + 1'b1);
               end else if (!is_space && !is_hash) begin
                  phase_cons = PH_ERROR;
               end
            end
            PH_W_DIG, PH_H_DIG: begin
               if (is_digit) begin
                  if (dim_over) begin
                     phase_cons = PH_ERROR;
                  end
               end else begin
                  phase_cons = phase_type'(phase_ff + 1'b1);
               end
            end
            PH_M_DIG: begin
               if (!is_digit) begin
                  phase_cons = PH_PAYLOAD;
               end
            end
            default: begin
               phase_cons = phase_ff;
            end
         endcase
      end
      if (done) begin
         phase_in = PH_MAGIC_P;
      end else if (q_pop) begin
         phase_in = phase_cons;
      end else begin
         phase_in = phase_ff;
      end
   end

   // datapath and end-of-file record
   always_comb begin
      comment_cons = comment_ff;
      acc_cons     = acc_ff;
      width_cons   = width_ff;
      height_cons  = height_ff;
      maxval_cons  = maxval_ff;
      color_cons   = color_ff;
      count_cons   = count_ff;
      err_cons     = err_ff;

      if (phase_ff != PH_ERROR && comment_ff) begin
         comment_cons = (q_item.cls != CL_NEWLINE);
      end else if (active) begin
         case (phase_ff)
            PH_MAGIC_P: begin
               if (q_item.cls != CL_LETTER_P) begin
                  err_cons = ST_MAGIC;
               end
            end
            PH_MAGIC_T: begin
               color_cons = (q_item.digit == DIGIT_COLOR);
               if (!(is_digit && (q_item.digit == DIGIT_GRAY ||
                                  q_item.digit == DIGIT_COLOR))) begin
                  color_cons = color_ff;
                  err_cons   = ST_TYPE;
               end
            end
            PH_W_SKIP, PH_H_SKIP, PH_M_SKIP: begin
               if (is_digit) begin
                  acc_cons = ACC_BITS'(q_item.digit);
               end else if (is_hash) begin
                  comment_cons = 1'b1;
               end else if (!is_space) begin
                  err_cons = ST_NUMBER;
               end
            end
            PH_W_DIG, PH_H_DIG, PH_M_DIG: begin
               if (is_digit) begin
                  if (phase_ff == PH_M_DIG) begin
                     acc_cons = (sum > SUM_BITS'(MAXVAL_SAT)) ? ACC_BITS'(MAXVAL_SAT)
                                                               : ACC_BITS'(sum);
                  end else if (dim_over) begin
                     err_cons = ST_OVERFLOW;
                  end else begin
                     acc_cons = ACC_BITS'(sum);
                  end
               end else begin
                  if (phase_ff == PH_W_DIG) begin
                     width_cons = DIM_BITS'(acc_ff);
                  end else if (phase_ff == PH_H_DIG) begin
                     height_cons = DIM_BITS'(acc_ff);
                  end else begin
                     maxval_cons = MAXV_BITS'(acc_ff);
                  end
                  acc_cons     = '0;
                  comment_cons = is_hash;
               end
            end
            PH_PAYLOAD: begin
               if (count_ff != CNT_SAT) begin
                  count_cons = count_ff + 1'b1;
               end
            end
            default: begin
               err_cons = err_ff;
            end
         endcase
      end

      // result of the file if this byte is the last one
      fin_in.status   = ST_NUMBER;
      fin_in.check    = 1'b0;
      fin_in.is_color = color_cons;
      fin_in.width    = width_cons;
      fin_in.height   = height_cons;
      fin_in.maxval   = maxval_cons;
      fin_in.count    = count_cons;
      case (phase_cons)
         PH_ERROR:   fin_in.status = err_cons;
         PH_MAGIC_P: fin_in.status = ST_MAGIC;
         PH_MAGIC_T: fin_in.status = ST_TYPE;
         PH_W_DIG:   fin_in.width  = DIM_BITS'(acc_cons);
         PH_H_DIG:   fin_in.height = DIM_BITS'(acc_cons);
         PH_M_DIG: begin
            fin_in.maxval = MAXV_BITS'(acc_cons);
            fin_in.check  = 1'b1;
            fin_in.status = ST_OK;
         end
         PH_PAYLOAD: begin
            fin_in.check  = 1'b1;
            fin_in.status = ST_OK;
         end
         default: fin_in.status = ST_NUMBER;
      endcase

      if (done) begin
         comment_in = 1'b0;
         acc_in     = '0;
         width_in   = '0;
         height_in  = '0;
         maxval_in  = '0;
         color_in   = 1'b0;
         count_in   = '0;
         err_in     = ST_OK;
      end else if (q_pop) begin
         comment_in = comment_cons;
         acc_in     = acc_cons;
         width_in   = width_cons;
         height_in  = height_cons;
         maxval_in  = maxval_cons;
         color_in   = color_cons;
         count_in   = count_cons;
         err_in     = err_cons;
      end else begin
         comment_in = comment_ff;
         acc_in     = acc_ff;
         width_in   = width_ff;
         height_in  = height_ff;
         maxval_in  = maxval_ff;
         color_in   = color_ff;
         count_in   = count_ff;
         err_in     = err_ff;
      end

      fin_valid_in = done || (fin_valid_ff && !fin_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_MAGIC_P;
         comment_ff   <= 1'b0;
         acc_ff       <= '0;
         width_ff     <= '0;
         height_ff    <= '0;
         maxval_ff    <= '0;
         color_ff     <= 1'b0;
         count_ff     <= '0;
         err_ff       <= ST_OK;
         fin_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         comment_ff   <= comment_in;
         acc_ff       <= acc_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         maxval_ff    <= maxval_in;
         color_ff     <= color_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         fin_valid_ff <= fin_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         fin_ff <= fin_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/nph_check.sv
// Size check pipeline: width*height, channel scaling, compare, response register.
`default_nettype none

module nph_check import nph_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    fin_valid,
   input  wire fin_type fin,
   output logic         fin_ready,
   nph_rsp_if.source    rsp_chan
);

   logic         s1_valid_ff, s1_valid_in;
   fin_type      s1_ff;
   prod_type     prod_ff;
   logic         out_valid_ff, out_valid_in;
   status_type   status_ff, status_in;
   logic         color_ff;
   out_dim_type  width_ff, height_ff;
   out_maxv_type maxval_ff;

   logic         s1_free, s2_free;
   cnt_type      expect_cnt;

   assign s2_free   = !out_valid_ff || rsp_chan.ready;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign fin_ready = s1_free;

   always_comb begin
      expect_cnt = CNT_BITS'(prod_ff);
      if (s1_ff.is_color) begin
         expect_cnt = (CNT_BITS'(prod_ff) << 1) + CNT_BITS'(prod_ff);
      end
      status_in = s1_ff.status;
      if (s1_ff.check) begin
         if (s1_ff.count != expect_cnt) begin
            status_in = ST_SIZE;
         end else if (s1_ff.maxval > MAXV_BITS'(MAXVAL_LIMIT)) begin
            status_in = ST_MAXVAL;
         end else begin
            status_in = ST_OK;
         end
      end
      s1_valid_in  = s1_free ? fin_valid : s1_valid_ff;
      out_valid_in = s2_free ? s1_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free && fin_valid) begin
         s1_ff   <= fin;
         prod_ff <= PROD_BITS'(fin.width) * PROD_BITS'(fin.height);
      end
      if (s2_free && s1_valid_ff) begin
         status_ff <= status_in;
         color_ff  <= s1_ff.is_color;
         width_ff  <= sat_dim(s1_ff.width);
         height_ff <= sat_dim(s1_ff.height);
         maxval_ff <= sat_maxv(s1_ff.maxval);
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.status       = status_ff;
   assign rsp_chan.is_color     = color_ff;
   assign rsp_chan.image_width  = width_ff;
   assign rsp_chan.image_height = height_ff;
   assign rsp_chan.max_value    = maxval_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/netpbm_header_parser_top.sv
// Top level of the netpbm P5/P6 header parser and payload size checker.
//
// Usage:
//   req_chan carries one byte of a netpbm file per request, with end_of_file
//   set on the last byte. rsp_chan gives exactly one response per file, on
//   its last byte: status (ok, bad magic, bad type, bad number, overflow,
//   size mismatch, maxval over 255), is_color, width, height, max value.
//   Throughput: one request per cycle, sustained, including files that are
//   a single byte long, while rsp_chan.ready is high; the parser state
//   machine takes one byte per cycle. After its last byte is written into
//   the queue, a response passes the parser record register, the
//   width*height multiplier register and the compare/response register.
//   Reset: synchronous, active high. Parser returns to "expect P", queue
//   and pipeline are emptied; no response is pending afterwards.
//   Stall: if rsp_chan.ready is low the response holds in its output
//   register while the check pipeline and the 4-entry byte queue keep
//   filling; req_chan.ready drops only when the queue is full. Non-final
//   bytes keep flowing through the parser even while an end-of-file record
//   is blocked; only a final byte waits for the record register.
`default_nettype none

module netpbm_header_parser_top import nph_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   nph_req_if.sink    req_chan,
   nph_rsp_if.source  rsp_chan
);

   logic     q_full;
   logic     q_push;
   item_type q_push_item;
   logic     q_pop;
   item_type q_pop_item;
   logic     q_not_empty;

   logic     fin_valid;
   fin_type  fin;
   logic     fin_ready;

   // byte classification
   nph_front u_front (
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_item   (q_push_item)
   );

   // decouples the request side from the parser
   nph_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (q_pop_item),
      .not_empty (q_not_empty)
   );

   // header state machine, payload count
   nph_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_not_empty),
      .q_item    (q_pop_item),
      .q_pop     (q_pop),
      .fin_valid (fin_valid),
      .fin       (fin),
      .fin_ready (fin_ready)
   );

   // size compare and response register
   nph_check u_check (
      .clock     (clock),
      .reset     (reset),
      .fin_valid (fin_valid),
      .fin       (fin),
      .fin_ready (fin_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire
